FILE: hdl/psev_pkg.sv
`timescale 1ns / 1ps
// psev_pkg: shared constants, codes and types for the postfix stack evaluator.
// No dependencies; used by every module in hdl/.
package psev_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int SP_W        = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int DATA_W      = 32;
   localparam int OPC_W       = 3;
   localparam int STAT_W      = 2;
   localparam int DEPTH_OUT_W = 5;
   localparam int CNT_W       = $clog2(DATA_W);

   // opcodes
   localparam logic [OPC_W-1:0] OP_PUSH = 3'd0;
   localparam logic [OPC_W-1:0] OP_NEG  = 3'd1;
   localparam logic [OPC_W-1:0] OP_ADD  = 3'd2;
   localparam logic [OPC_W-1:0] OP_SUB  = 3'd3;
   localparam logic [OPC_W-1:0] OP_MUL  = 3'd4;
   localparam logic [OPC_W-1:0] OP_DIV  = 3'd5;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_UNDER = 2'd1;
   localparam logic [STAT_W-1:0] STAT_OVER  = 2'd2;
   localparam logic [STAT_W-1:0] STAT_DIVZ  = 2'd3;

   typedef enum logic [2:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_NEG,
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   typedef enum logic [2:0] {
      SQ_IDLE,
      SQ_DECODE,
      SQ_READ,
      SQ_ALU,
      SQ_DONE
   } seq_state_type;

   typedef enum logic [2:0] {
      AL_IDLE,
      AL_EXEC,
      AL_DMAG,
      AL_STEP,
      AL_FIX
   } alu_state_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_req_type;

   typedef struct packed {
      logic done;
      logic div_zero;
   } alu_rsp_type;

endpackage

FILE: hdl/psev_stack_ram.sv
`timescale 1ns / 1ps
// psev_stack_ram: stack storage below the top entry, one write and one read port.
// Depends on psev_pkg for depth and widths. Read data is registered.
module psev_stack_ram (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [psev_pkg::ADDR_W-1:0] wr_addr,
   input  logic [psev_pkg::DATA_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [psev_pkg::ADDR_W-1:0] rd_addr,
   output logic [psev_pkg::DATA_W-1:0] rd_data
);

   logic [psev_pkg::DATA_W-1:0] mem [psev_pkg::STACK_DEPTH];
   logic [psev_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/psev_alu.sv
`timescale 1ns / 1ps
// psev_alu: shared 33-bit adder for add, subtract, negate and restoring division,
// plus a 32x32 low-word multiplier. Depends on psev_pkg.
module psev_alu (
   input  logic                        clock,
   input  logic                        reset,
   input  psev_pkg::alu_req_type       alu_req,
   input  logic [psev_pkg::DATA_W-1:0] opnd_a,
   input  logic [psev_pkg::DATA_W-1:0] opnd_b,
   output psev_pkg::alu_rsp_type       alu_rsp,
   output logic [psev_pkg::DATA_W-1:0] alu_result
);

   localparam int DW    = psev_pkg::DATA_W;
   localparam int ADD_W = DW + 2;
   localparam logic [psev_pkg::CNT_W-1:0] LAST_STEP = psev_pkg::CNT_W'(DW - 1);

   psev_pkg::alu_state_type state_ff, state_in;
   psev_pkg::alu_op_type    op_ff, op_in;
   logic [DW-1:0]           a_ff, a_in, b_ff, b_in;
   logic [DW-1:0]           quo_ff, quo_in, dmag_ff, dmag_in, res_ff, res_in;
   logic [DW:0]             rem_ff, rem_in;
   logic [psev_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                    sign_ff, sign_in;
   logic                    done_ff, done_in, dz_ff, dz_in;

   logic [DW:0]    add_x, add_y, rem_shift;
   logic           add_cin;
   logic [ADD_W-1:0] sum;
   logic [DW-1:0]  product;

   assign sum     = {1'b0, add_x} + {1'b0, add_y} + {{(ADD_W-1){1'b0}}, add_cin};
   assign product = a_ff * b_ff;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      quo_in    = quo_ff;
      dmag_in   = dmag_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      sign_in   = sign_ff;
      res_in    = res_ff;
      dz_in     = dz_ff;
      done_in   = 1'b0;
      add_x     = '0;
      add_y     = '0;
      add_cin   = 1'b0;
      rem_shift = {rem_ff[DW-1:0], quo_ff[DW-1]};
      case (state_ff)
         psev_pkg::AL_IDLE: begin
            if (alu_req.start) begin
               a_in     = opnd_a;
               b_in     = opnd_b;
               op_in    = alu_req.op;
               state_in = psev_pkg::AL_EXEC;
            end
         end
         psev_pkg::AL_EXEC: begin
            state_in = psev_pkg::AL_IDLE;
            done_in  = 1'b1;
            dz_in    = 1'b0;
            case (op_ff)
               psev_pkg::ALU_ADD: begin
                  add_x  = {1'b0, a_ff};
                  add_y  = {1'b0, b_ff};
                  res_in = sum[DW-1:0];
               end
               psev_pkg::ALU_SUB: begin
                  add_x   = {1'b0, a_ff};
                  add_y   = {1'b0, ~b_ff};
                  add_cin = 1'b1;
                  res_in  = sum[DW-1:0];
               end
               psev_pkg::ALU_NEG: begin
                  add_y   = {1'b0, ~a_ff};
                  add_cin = 1'b1;
                  res_in  = sum[DW-1:0];
               end
               psev_pkg::ALU_MUL: begin
                  res_in = product;
               end
               psev_pkg::ALU_DIV: begin
                  if (b_ff == '0) begin
                     dz_in = 1'b1;
                  end else begin
                     // numerator magnitude goes into the quotient shifter
                     add_y    = {1'b0, ~a_ff};
                     add_cin  = 1'b1;
                     quo_in   = a_ff[DW-1] ? sum[DW-1:0] : a_ff;
                     done_in  = 1'b0;
                     state_in = psev_pkg::AL_DMAG;
                  end
               end
               default: begin
                  res_in = '0;
               end
            endcase
         end
         psev_pkg::AL_DMAG: begin
            add_y    = {1'b0, ~b_ff};
            add_cin  = 1'b1;
            dmag_in  = b_ff[DW-1] ? sum[DW-1:0] : b_ff;
            rem_in   = '0;
            cnt_in   = '0;
            sign_in  = a_ff[DW-1] ^ b_ff[DW-1];
            state_in = psev_pkg::AL_STEP;
         end
         psev_pkg::AL_STEP: begin
            // trial subtract; carry out means remainder >= divisor
            add_x   = rem_shift;
            add_y   = ~{1'b0, dmag_ff};
            add_cin = 1'b1;
            if (sum[ADD_W-1]) begin
               rem_in = sum[DW:0];
               quo_in = {quo_ff[DW-2:0], 1'b1};
            end else begin
               rem_in = rem_shift;
               quo_in = {quo_ff[DW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + psev_pkg::CNT_W'(1);
            if (cnt_ff == LAST_STEP) begin
               state_in = psev_pkg::AL_FIX;
            end
         end
         psev_pkg::AL_FIX: begin
            add_y    = {1'b0, ~quo_ff};
            add_cin  = 1'b1;
            res_in   = sign_ff ? sum[DW-1:0] : quo_ff;
            dz_in    = 1'b0;
            done_in  = 1'b1;
            state_in = psev_pkg::AL_IDLE;
         end
         default: begin
            state_in = psev_pkg::AL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psev_pkg::AL_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      quo_ff  <= quo_in;
      dmag_ff <= dmag_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      sign_ff <= sign_in;
      res_ff  <= res_in;
      dz_ff   <= dz_in;
   end

   assign alu_rsp.done     = done_ff;
   assign alu_rsp.div_zero = dz_ff;
   assign alu_result       = res_ff;

endmodule

FILE: hdl/postfix_stack_evaluator.sv
`timescale 1ns / 1ps
// postfix_stack_evaluator: top level, sequencer, top-of-stack register, result beat.
// Depends on psev_pkg, psev_stack_ram and psev_alu.
//
//   channel   ports                                   direction  role
//   req       req_valid req_stall req_opcode          in         one op per beat
//             req_operand_value
//   rsp       rsp_valid rsp_stall rsp_top_value       out        one result per req beat
//             rsp_stack_depth rsp_status
//   csr       csr_valid csr_ready csr_data            in         operand_order register
//
// Steps per beat: push, spare ops, underflow and overflow go from decode to the result;
// negate runs the ALU; add, subtract, multiply and divide first read an operand from
// the RAM; a nonzero divide is slowest, set by the bit-serial divider loop (32 trial
// subtracts through the shared adder plus operand read, magnitude, sign and handshake steps).
// req_stall is high from acceptance until the result is loaded into the output
// register. A stalled result holds the sequencer only if a new one is ready.
// Reset is synchronous: the stack empties, operand_order clears, no result pending.
module postfix_stack_evaluator (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [psev_pkg::OPC_W-1:0]               req_opcode,
   input  logic signed [psev_pkg::DATA_W-1:0]       req_operand_value,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [psev_pkg::DATA_W-1:0]       rsp_top_value,
   output logic [psev_pkg::DEPTH_OUT_W-1:0]         rsp_stack_depth,
   output logic [psev_pkg::STAT_W-1:0]              rsp_status,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic                                     csr_data
);

   localparam int DW   = psev_pkg::DATA_W;
   localparam int SPW  = psev_pkg::SP_W;
   localparam int AW   = psev_pkg::ADDR_W;
   localparam int DOW  = psev_pkg::DEPTH_OUT_W;
   localparam logic [SPW-1:0] SP_FULL = SPW'(psev_pkg::STACK_DEPTH);

   psev_pkg::seq_state_type state_ff, state_in;

   // stack: the top entry lives in top_ff, the rest in the RAM
   logic [SPW-1:0] sp_ff, sp_in;
   logic [DW-1:0]  top_ff, top_in;
   logic           order_ff;

   logic [psev_pkg::OPC_W-1:0]  op_ff, op_in;
   logic [DW-1:0]               val_ff, val_in;
   logic [psev_pkg::STAT_W-1:0] status_ff, status_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]               rsp_top_ff, rsp_top_in;
   logic [DOW-1:0]              rsp_depth_ff, rsp_depth_in;
   logic [psev_pkg::STAT_W-1:0] rsp_status_ff, rsp_status_in;

   logic           wr_en, rd_en;
   logic [AW-1:0]  wr_addr, rd_addr;
   logic [DW-1:0]  rd_data;

   psev_pkg::alu_req_type alu_req;
   psev_pkg::alu_rsp_type alu_rsp;
   logic [DW-1:0]         opnd_a, opnd_b, alu_result;

   logic [SPW-1:0]     sp_minus1, sp_minus2;
   logic [SPW+DOW-1:0] depth_wide;

   assign sp_minus1  = sp_ff - SPW'(1);
   assign sp_minus2  = sp_ff - SPW'(2);
   assign depth_wide = {{DOW{1'b0}}, sp_ff};

   psev_stack_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (top_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   psev_alu u_alu (
      .clock      (clock),
      .reset      (reset),
      .alu_req    (alu_req),
      .opnd_a     (opnd_a),
      .opnd_b     (opnd_b),
      .alu_rsp    (alu_rsp),
      .alu_result (alu_result)
   );

   assign req_stall = (state_ff != psev_pkg::SQ_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      state_in      = state_ff;
      sp_in         = sp_ff;
      top_in        = top_ff;
      op_in         = op_ff;
      val_in        = val_ff;
      status_in     = status_ff;
      rsp_top_in    = rsp_top_ff;
      rsp_depth_in  = rsp_depth_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      wr_en         = 1'b0;
      wr_addr       = sp_minus1[AW-1:0];
      rd_en         = 1'b0;
      rd_addr       = sp_minus2[AW-1:0];
      alu_req.start = 1'b0;
      alu_req.op    = psev_pkg::ALU_ADD;
      opnd_a        = top_ff;
      opnd_b        = top_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         psev_pkg::SQ_IDLE: begin
            if (req_valid) begin
               op_in     = req_opcode;
               val_in    = req_operand_value;
               status_in = psev_pkg::STAT_OK;
               state_in  = psev_pkg::SQ_DECODE;
            end
         end
         psev_pkg::SQ_DECODE: begin
            state_in = psev_pkg::SQ_DONE;
            case (op_ff)
               psev_pkg::OP_PUSH: begin
                  if (sp_ff == SP_FULL) begin
                     status_in = psev_pkg::STAT_OVER;
                  end else begin
                     // old top drops into the RAM
                     wr_en  = (sp_ff != '0);
                     top_in = val_ff;
                     sp_in  = sp_ff + SPW'(1);
                  end
               end
               psev_pkg::OP_NEG: begin
                  if (sp_ff == '0) begin
                     status_in = psev_pkg::STAT_UNDER;
                  end else begin
                     alu_req.start = 1'b1;
                     alu_req.op    = psev_pkg::ALU_NEG;
                     state_in      = psev_pkg::SQ_ALU;
                  end
               end
               psev_pkg::OP_ADD, psev_pkg::OP_SUB, psev_pkg::OP_MUL, psev_pkg::OP_DIV: begin
                  if (sp_ff < SPW'(2)) begin
                     status_in = psev_pkg::STAT_UNDER;
                  end else begin
                     rd_en    = 1'b1;
                     state_in = psev_pkg::SQ_READ;
                  end
               end
               default: begin
                  status_in = psev_pkg::STAT_OK;
               end
            endcase
         end
         psev_pkg::SQ_READ: begin
            // operand order only matters for subtract and divide
            alu_req.start = 1'b1;
            opnd_a        = order_ff ? top_ff : rd_data;
            opnd_b        = order_ff ? rd_data : top_ff;
            case (op_ff)
               psev_pkg::OP_SUB: alu_req.op = psev_pkg::ALU_SUB;
               psev_pkg::OP_MUL: alu_req.op = psev_pkg::ALU_MUL;
               psev_pkg::OP_DIV: alu_req.op = psev_pkg::ALU_DIV;
               default:          alu_req.op = psev_pkg::ALU_ADD;
            endcase
            state_in = psev_pkg::SQ_ALU;
         end
         psev_pkg::SQ_ALU: begin
            if (alu_rsp.done) begin
               if (alu_rsp.div_zero) begin
                  status_in = psev_pkg::STAT_DIVZ;
               end else begin
                  top_in = alu_result;
                  if (op_ff != psev_pkg::OP_NEG) begin
                     sp_in = sp_minus1;
                  end
               end
               state_in = psev_pkg::SQ_DONE;
            end
         end
         psev_pkg::SQ_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_top_in    = (sp_ff != '0) ? top_ff : '0;
               rsp_depth_in  = depth_wide[DOW-1:0];
               rsp_status_in = status_ff;
               state_in      = psev_pkg::SQ_IDLE;
            end
         end
         default: begin
            state_in = psev_pkg::SQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= psev_pkg::SQ_IDLE;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         order_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            order_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      top_ff        <= top_in;
      op_ff         <= op_in;
      val_ff        <= val_in;
      status_ff     <= status_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_depth_ff  <= rsp_depth_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_top_value   = rsp_top_ff;
   assign rsp_stack_depth = rsp_depth_ff;
   assign rsp_status      = rsp_status_ff;

endmodule
